FILE: hdl/i2cbm_pkg.sv
// Package with the request and result types and the shared constants of the I2C master.
package i2cbm_pkg;

    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 2'd1;

    localparam logic [BYTE_W-1:0] HALF_PERIOD_RESET = 8'd80;
    localparam logic [BYTE_W-1:0] POLL_LIMIT_RESET  = 8'd50;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              send_ack;
        logic              sda_in;
    } req_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_enable;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_seen;
        logic              cmd_rejected;
    } res_t;

endpackage

FILE: hdl/i2c_bit_level_master.sv
// Byte-level I2C master that sequences SCL and SDA phases from tick requests.
// A request's result enters the output register in the cycle after acceptance.
// Throughput: one request per cycle; the single next-state pass and the result register
// set this, and a request is taken whenever the result register is empty or being read.
// Bus timing is set by half_period_reg ticks per half-phase, not by the clock rate.
// Reset: bus released (SCL high, SDA not driven), idle, registers at 80 and 50.
module i2c_bit_level_master
    import i2cbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  req_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output res_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_SA   = 4'd1;
    localparam logic [3:0] PH_SB   = 4'd2;
    localparam logic [3:0] PH_SC   = 4'd3;
    localparam logic [3:0] PH_PA   = 4'd4;
    localparam logic [3:0] PH_PB   = 4'd5;
    localparam logic [3:0] PH_WL   = 4'd6;
    localparam logic [3:0] PH_WH   = 4'd7;
    localparam logic [3:0] PH_WT   = 4'd8;
    localparam logic [3:0] PH_AS   = 4'd9;
    localparam logic [3:0] PH_AP   = 4'd10;
    localparam logic [3:0] PH_AF   = 4'd11;
    localparam logic [3:0] PH_RL   = 4'd12;
    localparam logic [3:0] PH_RH   = 4'd13;
    localparam logic [3:0] PH_RT   = 4'd14;

    logic [BYTE_W-1:0] half_period_reg;
    logic [BYTE_W-1:0] poll_limit_reg;

    logic [3:0]        phase_reg, phase_next;
    logic [3:0]        bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0] tick_count_reg, tick_count_next;
    logic [BYTE_W-1:0] poll_count_reg, poll_count_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              sda_oe_reg, sda_oe_next;
    logic              ack_reg, ack_next;
    logic              ack_choice_reg, ack_choice_next;
    logic [BYTE_W-1:0] last_read_reg, last_read_next;

    logic              out_valid_reg;
    res_t              out_data_reg, out_data_next;

    logic              accept;
    logic              done;
    logic              rejected;
    logic [BYTE_W-1:0] hp;
    logic [BYTE_W-1:0] lim;
    logic [BYTE_W-1:0] tick_inc;
    logic [BYTE_W-1:0] poll_inc;
    logic [3:0]        bit_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hp       = (half_period_reg == '0) ? BYTE_W'(1) : half_period_reg;
    assign lim      = (poll_limit_reg == '0) ? BYTE_W'(1) : poll_limit_reg;
    assign tick_inc = tick_count_reg + BYTE_W'(1);
    assign poll_inc = poll_count_reg + BYTE_W'(1);
    assign bit_inc  = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        poll_count_next = poll_count_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_oe_next     = sda_oe_reg;
        ack_next        = ack_reg;
        ack_choice_next = ack_choice_reg;
        last_read_next  = last_read_reg;
        done            = 1'b0;
        rejected        = 1'b0;

        if (in_data.cmd == CMD_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= hp)
                begin
                    tick_count_next = '0;
                    case (phase_reg)
                        PH_SA:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_SB;
                        end
                        PH_SB:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_SC;
                        end
                        PH_SC:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_PA:
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_PB;
                        end
                        PH_PB:
                        begin
                            sda_oe_next = 1'b0;
                            phase_next  = PH_IDLE;
                            done        = 1'b1;
                        end
                        PH_WL:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_WH;
                        end
                        PH_WH:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_WT;
                        end
                        PH_WT:
                        begin
                            bit_count_next = bit_inc;
                            if (bit_inc < 4'd8)
                            begin
                                sda_next   = shift_reg[BYTE_W-1];
                                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                                phase_next = PH_WL;
                            end
                            else
                            begin
                                sda_oe_next     = 1'b0;
                                sda_next        = 1'b1;
                                poll_count_next = '0;
                                phase_next      = PH_AS;
                            end
                        end
                        PH_AS:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_AP;
                        end
                        PH_AP:
                        begin
                            if (!in_data.sda_in)
                            begin
                                ack_next   = 1'b1;
                                scl_next   = 1'b0;
                                phase_next = PH_AF;
                            end
                            else
                            begin
                                poll_count_next = poll_inc;
                                if (poll_inc >= lim)
                                begin
                                    ack_next   = 1'b0;
                                    scl_next   = 1'b0;
                                    phase_next = PH_AF;
                                end
                            end
                        end
                        PH_AF:
                        begin
                            sda_oe_next = 1'b1;
                            phase_next  = PH_IDLE;
                            done        = 1'b1;
                        end
                        PH_RL:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_RH;
                        end
                        PH_RH:
                        begin
                            if (bit_count_reg < 4'd8)
                            begin
                                shift_next = {shift_reg[BYTE_W-2:0], in_data.sda_in};
                            end
                            scl_next   = 1'b0;
                            phase_next = PH_RT;
                        end
                        PH_RT:
                        begin
                            bit_count_next = bit_inc;
                            if (bit_inc < 4'd8)
                            begin
                                phase_next = PH_RL;
                            end
                            else if (bit_inc == 4'd8)
                            begin
                                sda_oe_next = 1'b1;
                                sda_next    = !ack_choice_reg;
                                phase_next  = PH_RL;
                            end
                            else
                            begin
                                last_read_next = shift_reg;
                                phase_next     = PH_IDLE;
                                done           = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
        else if (phase_reg != PH_IDLE || in_data.cmd > CMD_READ)
        begin
            rejected = 1'b1;
        end
        else
        begin
            tick_count_next = '0;
            case (in_data.cmd)
                CMD_START:
                begin
                    sda_oe_next = 1'b1;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                    phase_next  = PH_SA;
                end
                CMD_STOP:
                begin
                    sda_oe_next = 1'b1;
                    sda_next    = 1'b0;
                    scl_next    = 1'b1;
                    phase_next  = PH_PA;
                end
                CMD_WRITE:
                begin
                    sda_oe_next    = 1'b1;
                    ack_next       = 1'b0;
                    bit_count_next = '0;
                    sda_next       = in_data.data_byte[BYTE_W-1];
                    shift_next     = {in_data.data_byte[BYTE_W-2:0], 1'b0};
                    phase_next     = PH_WL;
                end
                default:
                begin
                    sda_oe_next     = 1'b0;
                    shift_next      = '0;
                    bit_count_next  = '0;
                    ack_choice_next = in_data.send_ack;
                    phase_next      = PH_RL;
                end
            endcase
        end

        out_data_next.scl_level    = scl_next;
        out_data_next.sda_level    = sda_next;
        out_data_next.sda_enable   = sda_oe_next;
        out_data_next.busy_res     = (phase_next != PH_IDLE);
        out_data_next.done_res     = done;
        out_data_next.read_data    = last_read_next;
        out_data_next.ack_seen     = ack_next;
        out_data_next.cmd_rejected = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            poll_limit_reg  <= POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HALF_PERIOD)
            begin
                half_period_reg <= cfg_wdata;
            end
            else if (cfg_index == CFG_POLL_LIMIT)
            begin
                poll_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            tick_count_reg <= '0;
            poll_count_reg <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_oe_reg     <= 1'b0;
            ack_reg        <= 1'b0;
            ack_choice_reg <= 1'b0;
            last_read_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            poll_count_reg <= poll_count_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            sda_oe_reg     <= sda_oe_next;
            ack_reg        <= ack_next;
            ack_choice_reg <= ack_choice_next;
            last_read_reg  <= last_read_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: hdl/i2cbm_checker.sv
// Port-level checker for the I2C master and the bind that attaches it.
module i2cbm_checker
    import i2cbm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input req_t                  in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input res_t                  out_data,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    // A result that is not taken holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // No request is taken while a stalled result occupies the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken over a stalled result");

    // A completed command always leaves the master idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("completion reported while busy");

    // A rejected request never completes a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.cmd_rejected |-> !out_data.done_res)
        else $error("rejected request reported completion");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);
